// ----- rtl/sdx_pkg.sv -----
`timescale 1ns / 1ps

package sdx_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_END   = 2'd1;
  localparam logic [1:0] CFG_CHECK = 2'd2;

  localparam logic [7:0] START_RST = 8'd36;
  localparam logic [7:0] END_RST   = 8'd10;
  localparam logic [7:0] CHECK_RST = 8'd42;

  // Result status codes
  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [1:0] {
    S_HUNT,
    S_RECV,
    S_READ,
    S_SHOW
  } sdx_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic open;      // start a new sentence
    logic store;     // store byte, update xor / checksum digits
    logic err_ovf;   // load overflow result
    logic err_mis;   // load mismatch result
    logic rd_first;  // rewind payload read index
    logic rd;        // read one payload byte into the output register
  } sdx_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_start;
    logic is_end;
    logic full;
    logic match;
    logic empty;
    logic out_last;
  } sdx_sts_t;

endpackage

// ----- rtl/sdx_if.sv -----
`timescale 1ns / 1ps

interface sdx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface sdx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output out_byte, output last, output status, input ready);
  modport sink (input valid, input out_byte, input last, input status, output ready);
endinterface

// ----- rtl/sentence_deframer_xor_check.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Payload                          Word accepted when
// in_ch     in   data_byte[7:0]                   valid && ready
// out_ch    out  out_byte[7:0], last, status[1:0] valid && ready
// cfg       in   cfg_idx_i[1:0], cfg_data_i[7:0]  cfg_we_i
//
// Input bytes take one cycle each while no result is pending.
// A good sentence of n payload bytes is sent in n words, each a registered
// store read followed by an output hold until taken; an error result takes
// one word. Input is stalled while results are in flight.
// Reset is asynchronous, active low; the payload store needs no clearing.

module sentence_deframer_xor_check #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  sdx_in_if.sink    in_ch,
  sdx_out_if.source out_ch
);
  import sdx_pkg::*;

  sdx_cmd_t cmd;
  sdx_sts_t sts;

  // Sequencer: hunt / receive / read store / present word
  sdx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .cmd_o       (cmd)
  );

  // Config regs, xor / hex checksum, payload store, output register
  sdx_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .data_byte_i  (in_ch.data_byte),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_byte_o   (out_ch.out_byte),
    .out_last_o   (out_ch.last),
    .out_status_o (out_ch.status)
  );

endmodule

// ----- rtl/sdx_ctrl.sv -----
`timescale 1ns / 1ps

module sdx_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  input  sdx_pkg::sdx_sts_t sts_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output sdx_pkg::sdx_cmd_t cmd_o
);
  import sdx_pkg::*;

  sdx_state_e state_q, state_d;
  logic       in_fire;
  logic       out_fire;

  assign in_ready_o  = (state_q == S_HUNT) || (state_q == S_RECV);
  assign out_valid_o = (state_q == S_SHOW);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_HUNT: begin
        if (in_fire && sts_i.is_start) state_d = S_RECV;
      end
      S_RECV: begin
        if (in_fire) begin
          if (sts_i.full) begin
            state_d = S_SHOW;
          end else if (sts_i.is_start) begin
            state_d = S_RECV;
          end else if (sts_i.is_end) begin
            if (!sts_i.match) state_d = S_SHOW;
            else if (sts_i.empty) state_d = S_HUNT;
            else state_d = S_READ;
          end
        end
      end
      S_READ: state_d = S_SHOW;
      S_SHOW: begin
        if (out_fire) state_d = sts_i.out_last ? S_HUNT : S_READ;
      end
      default: state_d = S_HUNT;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_HUNT: begin
        cmd_o.open = in_fire && sts_i.is_start;
      end
      S_RECV: begin
        if (in_fire) begin
          if (sts_i.full) begin
            cmd_o.err_ovf = 1'b1;
          end else if (sts_i.is_start) begin
            cmd_o.open = 1'b1;
          end else if (sts_i.is_end) begin
            cmd_o.err_mis  = !sts_i.match;
            cmd_o.rd_first = sts_i.match;
          end else begin
            cmd_o.store = 1'b1;
          end
        end
      end
      S_READ: cmd_o.rd = 1'b1;
      S_SHOW: ;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- rtl/sdx_dp.sv -----
`timescale 1ns / 1ps

module sdx_dp #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  input  logic [7:0]        data_byte_i,
  input  sdx_pkg::sdx_cmd_t cmd_i,
  output sdx_pkg::sdx_sts_t sts_o,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o,
  output logic [1:0]        out_status_o
);
  import sdx_pkg::*;

  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(BUFFER_DEPTH);

  logic [7:0]    start_q, end_q, check_q;
  logic          in_chk_q, hstop_q;
  logic [CW-1:0] fill_q, len_q, idx_q;
  logic [7:0]    xor_q, rsum_q;
  logic [7:0]    mem [BUFFER_DEPTH];
  logic [7:0]    out_byte_q;
  logic          out_last_q;
  logic [1:0]    out_status_q;
  logic [4:0]    hex;

  // {digit valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
      return {1'b1, v[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
      return {1'b1, v[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  assign hex = hex_val(data_byte_i);

  assign sts_o.is_start = (data_byte_i == start_q);
  assign sts_o.is_end   = (data_byte_i == end_q);
  assign sts_o.full     = (fill_q >= FULL_CNT);
  assign sts_o.match    = in_chk_q && (rsum_q == xor_q);
  assign sts_o.empty    = (len_q == '0);
  assign sts_o.out_last = out_last_q;

  assign out_byte_o   = out_byte_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RST;
      end_q   <= END_RST;
      check_q <= CHECK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START: start_q <= cfg_data_i;
        CFG_END:   end_q   <= cfg_data_i;
        CFG_CHECK: check_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sentence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_chk_q <= 1'b0;
      hstop_q  <= 1'b0;
      fill_q   <= '0;
      len_q    <= '0;
      xor_q    <= 8'd0;
      rsum_q   <= 8'd0;
      idx_q    <= '0;
    end else begin
      if (cmd_i.open) begin
        in_chk_q <= 1'b0;
        hstop_q  <= 1'b0;
        fill_q   <= '0;
        len_q    <= '0;
        xor_q    <= 8'd0;
        rsum_q   <= 8'd0;
      end else if (cmd_i.store) begin
        if (!in_chk_q) begin
          if (data_byte_i == check_q) begin
            in_chk_q <= 1'b1;
            len_q    <= fill_q;
          end else begin
            xor_q <= xor_q ^ data_byte_i;
          end
        end else if (!hstop_q) begin
          if (hex[4]) rsum_q <= {rsum_q[3:0], hex[3:0]};
          else hstop_q <= 1'b1;
        end
        fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.rd_first) idx_q <= '0;
      else if (cmd_i.rd) idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) mem[fill_q[AW-1:0]] <= data_byte_i;
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      out_byte_q   <= mem[idx_q[AW-1:0]];
      out_last_q   <= (CW'(idx_q + 1'b1) == len_q);
      out_status_q <= ST_GOOD;
    end else if (cmd_i.err_ovf || cmd_i.err_mis) begin
      out_byte_q   <= 8'd0;
      out_last_q   <= 1'b1;
      out_status_q <= cmd_i.err_ovf ? ST_OVERFLOW : ST_MISMATCH;
    end
  end

endmodule

// ----- rtl/sdx_checker.sv -----
`timescale 1ns / 1ps

module sdx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i,
  input logic [1:0] out_status_i
);
  import sdx_pkg::*;

  // Held word must not change while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i)
      && $stable(out_status_i))
    else $error("output word changed while stalled");

  // Input is stalled whenever a result word is pending
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while result pending");

  // Error words are zero and end their run
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == ST_MISMATCH || out_status_i == ST_OVERFLOW)
      |-> out_last_i && (out_byte_i == 8'd0))
    else $error("malformed error word");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i == ST_GOOD || out_status_i == ST_MISMATCH
      || out_status_i == ST_OVERFLOW))
    else $error("bad status code");

  // After a word is taken the next needs a store read first
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> !out_valid_i)
    else $error("back-to-back output words");

endmodule

bind sentence_deframer_xor_check sdx_checker u_sdx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .out_byte_i   (out_ch.out_byte),
  .out_last_i   (out_ch.last),
  .out_status_i (out_ch.status)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

// Sentence deframer bench.
// A directed table comes first, then random sentences under several register
// settings. Every accepted input word runs through a local deframer predictor,
// and every accepted output word is checked against the oldest predicted word.
module tb_top;
  import sdx_pkg::*;

  localparam int DEPTH = 64;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  sdx_in_if  in_if ();
  sdx_out_if out_if ();

  sentence_deframer_xor_check #(
    .BUFFER_DEPTH(DEPTH)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One output word as the block sends it.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] status;
  } result_t;

  // Directed rows either trust the predictor or carry their own answer.
  typedef enum logic [1:0] {
    ROW_MODEL,    // expectation comes from the predictor
    ROW_QUIET,    // no word may come out of this byte
    ROW_MISMATCH  // exactly one checksum-error word
  } row_kind_e;

  typedef struct packed {
    logic [7:0] data;
    row_kind_e  kind;
  } row_t;

  // Register setting per phase, with the running byte count it stops at.
  typedef struct packed {
    logic [7:0]  start_v;
    logic [7:0]  end_v;
    logic [7:0]  check_v;
    logic [15:0] upto;
  } phase_t;

  // Reset registers: start '$', end LF, check '*'.
  localparam int N_ROWS = 28;
  localparam row_t ROWS [N_ROWS] = '{
    '{8'h00, ROW_QUIET},     // hunting: low extreme ignored
    '{8'hFF, ROW_QUIET},     // hunting: high extreme ignored
    '{"$",   ROW_QUIET},
    '{8'h00, ROW_QUIET},     // payload extremes, xor = FF
    '{8'hFF, ROW_QUIET},
    '{"*",   ROW_QUIET},
    '{"f",   ROW_QUIET},     // lower and upper case hex digits
    '{"F",   ROW_QUIET},
    '{8'h0A, ROW_MODEL},     // good: 00, FF(last)
    '{"$",   ROW_QUIET},
    '{"x",   ROW_QUIET},
    '{8'h0A, ROW_MISMATCH},  // end with no check byte
    '{"$",   ROW_QUIET},
    '{"Q",   ROW_QUIET},
    '{"$",   ROW_QUIET},     // repeated start drops the 'Q'
    '{"1",   ROW_QUIET},
    '{"*",   ROW_QUIET},
    '{"3",   ROW_QUIET},
    '{"1",   ROW_QUIET},
    '{"g",   ROW_QUIET},     // non-hex stops digit reading
    '{"5",   ROW_QUIET},     // so this digit does not count
    '{8'h0A, ROW_MODEL},     // good: '1'(last)
    '{"$",   ROW_QUIET},
    '{"*",   ROW_QUIET},
    '{"1",   ROW_QUIET},     // three digits: 0x100 keeps low 8 bits = 00
    '{"0",   ROW_QUIET},
    '{"0",   ROW_QUIET},
    '{8'h0A, ROW_QUIET}      // match on empty payload sends nothing
  };

  localparam int N_PHASES = 7;
  localparam phase_t PHASES [N_PHASES] = '{
    '{START_RST, END_RST, CHECK_RST, 16'd180},
    '{8'h00,     8'hFF,   8'h80,     16'd240},
    '{8'hFF,     8'h00,   8'h01,     16'd300},
    '{8'h24,     8'h2A,   8'h2A,     16'd330},  // end == check: end wins
    '{8'h21,     8'h0D,   8'h21,     16'd360},  // start == check: start wins
    '{8'h80,     8'h01,   8'h00,     16'd410},
    '{8'h07,     8'hC8,   8'hFF,     16'd470}
  };

  // Predictor copy of the registers and the sentence state.
  logic [7:0] sh_start = START_RST;
  logic [7:0] sh_end   = END_RST;
  logic [7:0] sh_check = CHECK_RST;
  logic       sh_receiving = 1'b0;
  logic       sh_in_sum    = 1'b0;
  logic       sh_hex_halt  = 1'b0;
  logic [6:0] sh_fill      = '0;
  logic [6:0] sh_plen      = '0;
  logic [7:0] sh_xor       = '0;
  logic [7:0] sh_rx_sum    = '0;
  logic [7:0] sh_store [DEPTH];

  result_t   step_words [$];  // words caused by the byte just deframed
  result_t   awaited_q [$];   // words still owed by the block
  row_kind_e row_kind;

  int err_count  = 0;
  int bytes_sent = 0;
  int words_seen = 0;
  int n_good     = 0;
  int n_mis      = 0;
  int n_ovf      = 0;
  int tx_left    = 0;
  bit tx_brisk   = 1'b0;

  task automatic report(input string what);
    err_count++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // Returns {valid, value}; accepts 0-9, a-f, A-F.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic void clear_sentence(input logic rx);
    sh_receiving = rx;
    sh_in_sum    = 1'b0;
    sh_hex_halt  = 1'b0;
    sh_fill      = '0;
    sh_plen      = '0;
    sh_xor       = '0;
    sh_rx_sum    = '0;
  endfunction

  // Advance the predictor by one received byte; fills step_words.
  function automatic void deframe_byte(input logic [7:0] b);
    logic [4:0] nib;
    step_words.delete();
    if (!sh_receiving) begin
      if (b == sh_start) clear_sentence(1'b1);
    end else if (sh_fill >= DEPTH) begin
      // store full: this byte is lost whatever it is
      clear_sentence(1'b0);
      step_words.push_back(result_t'{8'h00, 1'b1, ST_OVERFLOW});
    end else if (b == sh_start) begin
      clear_sentence(1'b1);
    end else if (b == sh_end) begin
      if (sh_in_sum && sh_rx_sum == sh_xor) begin
        for (int k = 0; k < sh_plen; k++)
          step_words.push_back(result_t'{sh_store[k], (k + 1 == sh_plen), ST_GOOD});
      end else begin
        step_words.push_back(result_t'{8'h00, 1'b1, ST_MISMATCH});
      end
      clear_sentence(1'b0);
    end else begin
      if (!sh_in_sum) begin
        if (b == sh_check) begin
          sh_in_sum = 1'b1;
          sh_plen   = sh_fill;
        end else begin
          sh_xor ^= b;
        end
      end else if (!sh_hex_halt) begin
        nib = hex_nibble(b);
        if (!nib[4]) sh_hex_halt = 1'b1;
        else sh_rx_sum = {sh_rx_sum[3:0], nib[3:0]};
      end
      sh_store[sh_fill] = b;
      sh_fill++;
    end
  endfunction

  // Offer one input word after a random gap; returns at the next falling edge
  // with valid still high, so a back-to-back word needs no toggle.
  task automatic send_word(input logic [7:0] b, input row_kind_e kind = ROW_MODEL);
    int gap;
    if (tx_left == 0) begin
      tx_brisk = ($urandom_range(0, 2) == 0);
      tx_left  = $urandom_range(10, 40);
    end
    tx_left--;
    gap = tx_brisk ? 0 : $urandom_range(0, 18);
    repeat (gap) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    row_kind        <= kind;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Mostly clear of the framing bytes; now and then anything goes.
  function automatic logic [7:0] payload_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    while ($urandom_range(0, 19) != 0 && (v == sh_start || v == sh_end || v == sh_check))
      v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  // One random sentence. Mix:
  //   good; wrong digits; extra leading digits (shifted out of the low 8 bits);
  //   junk after the digits; no check byte; aborted start then good;
  //   store overflow; bare line noise.
  task automatic send_sentence();
    int         r;
    int         len;
    logic [7:0] sum;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r >= 92) begin
      repeat ($urandom_range(1, 6)) send_word(8'($urandom_range(0, 255)));
      return;
    end
    if (r >= 88) len = $urandom_range(64, 70);
    else if ($urandom_range(0, 19) == 0) len = $urandom_range(11, 63);
    else len = $urandom_range(0, 10);
    if (r >= 82 && r < 88) begin
      send_word(sh_start);
      repeat ($urandom_range(0, 5)) send_word(payload_byte());
    end
    send_word(sh_start);
    sum = '0;
    repeat (len) begin
      b = payload_byte();
      sum ^= b;
      send_word(b);
    end
    if (r < 78 || (r >= 82 && r < 88)) begin
      send_word(sh_check);
      if (r >= 65 && r < 72)
        repeat ($urandom_range(1, 3)) send_word(hex_char(4'($urandom)));
      if (r >= 55 && r < 65) sum ^= 8'($urandom_range(1, 255));
      send_word(hex_char(sum[7:4]));
      send_word(hex_char(sum[3:0]));
      if (r >= 72 && r < 78) begin
        send_word(8'h67 + 8'($urandom_range(0, 19)));  // 'g'..'z'
        send_word(hex_char(4'($urandom)));
      end
    end
    send_word(sh_end);
  endtask

  // Drop valid, let every owed word drain, then give the block time to go idle.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (awaited_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin : stimulus
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    row_kind        = ROW_MODEL;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_START;
    cfg_data_i      = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table under reset register values
    foreach (ROWS[i]) send_word(ROWS[i].data, ROWS[i].kind);

    foreach (PHASES[p]) begin
      settle();
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_START;
      cfg_data_i <= PHASES[p].start_v;
      @(negedge clk_i);
      cfg_idx_i  <= CFG_END;
      cfg_data_i <= PHASES[p].end_v;
      @(negedge clk_i);
      cfg_idx_i  <= CFG_CHECK;
      cfg_data_i <= PHASES[p].check_v;
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      sh_start = PHASES[p].start_v;
      sh_end   = PHASES[p].end_v;
      sh_check = PHASES[p].check_v;
      while (bytes_sent < PHASES[p].upto) send_sentence();
    end

    settle();
    repeat (20) @(negedge clk_i);
    $display("Run covered %0d input words over %0d register settings.",
             bytes_sent, N_PHASES);
    $display("Words out: %0d payload, %0d checksum errors, %0d overflows.",
             n_good, n_mis, n_ovf);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Output side: random stalls per word, plus one long hold-off early in the
  // run so pending payload backs up into the input.
  initial begin : drain
    int wait_n;
    int left;
    bit brisk;
    bit pressed;
    left    = 0;
    brisk   = 1'b0;
    pressed = 1'b0;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (!pressed && words_seen >= 30) begin
        pressed = 1'b1;
        out_if.ready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      if (left == 0) begin
        brisk = ($urandom_range(0, 2) == 0);
        left  = $urandom_range(10, 40);
      end
      left--;
      wait_n = brisk ? 0 : $urandom_range(0, 18);
      repeat (wait_n) begin
        out_if.ready <= 1'b0;
        @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
      @(negedge clk_i);
    end
  end

  // Watch both channels at the rising edge. Output is checked before the
  // input word of the same edge is deframed; the block cannot answer a byte
  // in the cycle it takes it.
  always @(posedge clk_i) begin : watch
    result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        words_seen++;
        case (out_if.status)
          ST_GOOD:     n_good++;
          ST_MISMATCH: n_mis++;
          ST_OVERFLOW: n_ovf++;
          default: ;
        endcase
        if (awaited_q.size() == 0) begin
          report($sformatf("unexpected word %02h/%0b/%0d",
                           out_if.out_byte, out_if.last, out_if.status));
        end else begin
          want = awaited_q.pop_front();
          if (out_if.out_byte !== want.out_byte || out_if.last !== want.last ||
              out_if.status !== want.status)
            report($sformatf("word %0d: got %02h/%0b/%0d, want %02h/%0b/%0d",
                             words_seen, out_if.out_byte, out_if.last, out_if.status,
                             want.out_byte, want.last, want.status));
        end
      end
      if (in_if.valid && in_if.ready) begin
        deframe_byte(in_if.data_byte);
        case (row_kind)
          ROW_MODEL:    foreach (step_words[i]) awaited_q.push_back(step_words[i]);
          ROW_MISMATCH: awaited_q.push_back(result_t'{8'h00, 1'b1, ST_MISMATCH});
          default: ;
        endcase
      end
    end
  end

  initial begin : watchdog
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sentence_deframer_xor_check.f -----
rtl/sdx_pkg.sv
rtl/sdx_if.sv
rtl/sdx_ctrl.sv
rtl/sdx_dp.sv
rtl/sentence_deframer_xor_check.sv
rtl/sdx_checker.sv
tb/sv/tb_top.sv
